// ----- rtl/br2_pkg.sv -----
package br2_pkg;

    // fixed field widths
    localparam int OPND_W = 32;
    localparam int PROD_W = 64;
    localparam int CFG_W  = 6;

    // operand width limits and reset value
    localparam int               MAX_WIDTH_DEF = 32;
    localparam logic [CFG_W-1:0] WIDTH_RESET   = 6'd8;
    localparam logic [CFG_W-1:0] WIDTH_MIN     = 6'd2;

    // booth bit pair {q lsb, previous bit}
    localparam logic [1:0] PAIR_SUB = 2'b10;
    localparam logic [1:0] PAIR_ADD = 2'b01;

endpackage

// ----- rtl/booth_radix2_multiplier.sv -----
// Signed radix-2 Booth multiplier. Takes one word per clock and returns one product word
// per clock while the output does not stall. Every word passes through MAX_WIDTH register
// stages, one Booth add-and-shift step each, plus an input and an output register; steps
// at or beyond the programmed width pass the word through unchanged, so latency does
// not depend on it.
// operand_width is clamped to 2..MAX_WIDTH and must only be written while the pipeline
// is empty. A stall on a valid output word freezes the whole pipeline and stalls the input.
module booth_radix2_multiplier
    import br2_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     operand_width_we,
    input  logic [CFG_W-1:0]         operand_width,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [OPND_W-1:0] multiplicand,
    input  logic signed [OPND_W-1:0] multiplier_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [PROD_W-1:0] product
);

    localparam int W = MAX_WIDTH;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] n_eff;
    logic [CFG_W-1:0] n_m1;
    logic [W-1:0]     ext_mask;
    logic [W-1:0]     msb_onehot;
    logic [W-1:0]     low_mask;

    logic             advance;

    logic [W:0]       valid_reg;
    logic [W-1:0]     a_reg    [0:W];
    logic [W-1:0]     q_reg    [0:W];
    logic [W-1:0]     m_reg    [0:W];
    logic             prev_reg [0:W];
    logic [W-1:0]     a_next   [0:W];
    logic [W-1:0]     q_next   [0:W];
    logic             prev_next[0:W];

    logic [W-1:0]     mc_in;
    logic             mc_sign;

    logic              out_valid_reg;
    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (operand_width_we)
        begin
            width_reg <= operand_width;
        end
    end

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
        begin
            n_eff = WIDTH_MIN;
        end
        else if (width_reg > CFG_W'(W))
        begin
            n_eff = CFG_W'(W);
        end
        else
        begin
            n_eff = width_reg;
        end
    end

    assign n_m1 = n_eff - CFG_W'(1);

    // bits at and above the sign position, and the sign position itself
    always_comb
    begin
        for (int k = 0; k < W; k++)
        begin
            ext_mask[k]   = (CFG_W'(k) >= n_m1);
            msb_onehot[k] = (CFG_W'(k) == n_m1);
        end
    end

    assign low_mask = ~ext_mask | msb_onehot;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // input stage: cut operands to n bits, multiplicand sign-extended
    assign mc_in   = multiplicand[W-1:0];
    assign mc_sign = |(mc_in & msb_onehot);

    always_comb
    begin
        a_next[0]    = '0;
        q_next[0]    = multiplier_value[W-1:0] & low_mask;
        prev_next[0] = 1'b0;
    end

    // one booth step per stage
    for (genvar i = 0; i < W; i++)
    begin : g_step
        logic [1:0]   pair;
        logic [W-1:0] addend;
        logic [W-1:0] sum;
        logic         sum_sign;
        logic [W-1:0] sum_ext;

        always_comb
        begin
            pair = {q_reg[i][0], prev_reg[i]};
            case (pair)
                PAIR_SUB: addend = -m_reg[i];
                PAIR_ADD: addend = m_reg[i];
                default:  addend = '0;
            endcase
            sum      = a_reg[i] + addend;
            // wrap to n bits, keep it sign-extended over the full register
            sum_sign = |(sum & msb_onehot);
            sum_ext  = (sum & ~ext_mask) | (ext_mask & {W{sum_sign}});
            if (CFG_W'(i) < n_eff)
            begin
                a_next[i+1]    = {sum_ext[W-1], sum_ext[W-1:1]};
                q_next[i+1]    = (q_reg[i] >> 1) | (msb_onehot & {W{sum_ext[0]}});
                prev_next[i+1] = q_reg[i][0];
            end
            else
            begin
                a_next[i+1]    = a_reg[i];
                q_next[i+1]    = q_reg[i];
                prev_next[i+1] = prev_reg[i];
            end
        end
    end

    // product = A * 2^n + Q, with A already sign-extended
    assign product_next = ({{(PROD_W-W){a_reg[W][W-1]}}, a_reg[W]} << n_eff)
                        | {{(PROD_W-W){1'b0}}, q_reg[W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[W-1:0], in_valid};
            out_valid_reg <= valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg[0]    <= a_next[0];
            q_reg[0]    <= q_next[0];
            m_reg[0]    <= (mc_in & ~ext_mask) | (ext_mask & {W{mc_sign}});
            prev_reg[0] <= prev_next[0];
            for (int s = 1; s <= W; s++)
            begin
                a_reg[s]    <= a_next[s];
                q_reg[s]    <= q_next[s];
                m_reg[s]    <= m_reg[s-1];
                prev_reg[s] <= prev_next[s];
            end
            product_reg <= product_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;

    // a stalled pipeline holds its occupancy
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(valid_reg) && out_valid))
        else $error("pipeline moved while output stalled");

    // the input only stalls when a finished word is held at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output word");

    // a word leaving the last step reaches the output register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[W] && !in_stall) |=> out_valid)
        else $error("word lost between last step and output");

endmodule
